// ===== rtl/acpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acpe_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP        = 2'd1;

  localparam logic [15:0] ALPHA_GAIN_RESET = 16'd4096;
  localparam logic [15:0] GAP_RESET        = 16'd4096;

  // 1.0 in Q30
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Largest Q16.16 magnitude
  localparam logic [31:0] SAT_Q16 = 32'h7FFF_FFFF;

  // exp(-1) in Q30, from the same truncated 15-term series as the datapath
  localparam logic [63:0] E1_T0  = 64'd1 << 30;
  localparam logic [63:0] E1_T1  = E1_T0 / 64'd1;
  localparam logic [63:0] E1_T2  = E1_T1 / 64'd2;
  localparam logic [63:0] E1_T3  = E1_T2 / 64'd3;
  localparam logic [63:0] E1_T4  = E1_T3 / 64'd4;
  localparam logic [63:0] E1_T5  = E1_T4 / 64'd5;
  localparam logic [63:0] E1_T6  = E1_T5 / 64'd6;
  localparam logic [63:0] E1_T7  = E1_T6 / 64'd7;
  localparam logic [63:0] E1_T8  = E1_T7 / 64'd8;
  localparam logic [63:0] E1_T9  = E1_T8 / 64'd9;
  localparam logic [63:0] E1_T10 = E1_T9 / 64'd10;
  localparam logic [63:0] E1_T11 = E1_T10 / 64'd11;
  localparam logic [63:0] E1_T12 = E1_T11 / 64'd12;
  localparam logic [63:0] E1_T13 = E1_T12 / 64'd13;
  localparam logic [63:0] E1_T14 = E1_T13 / 64'd14;
  localparam logic [29:0] EM1_Q30 = 30'(E1_T0 - E1_T1 + E1_T2 - E1_T3 + E1_T4 - E1_T5
                                         + E1_T6 - E1_T7 + E1_T8 - E1_T9 + E1_T10
                                         - E1_T11 + E1_T12 - E1_T13 + E1_T14);

  // Q30 magnitude to signed Q16.16 with saturation
  function automatic logic [31:0] to_q16(input logic [63:0] mag, input logic neg);
    logic [49:0] m;
    logic [31:0] r;
    m = mag[63:14];
    r = (|m[49:31]) ? SAT_Q16 : {1'b0, m[30:0]};
    return neg ? (32'd0 - r) : r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/acpe_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Requires num_i >> QW to be below den_i.
module acpe_div #(
  parameter int unsigned NW = 62,
  parameter int unsigned DW = 29,
  parameter int unsigned QW = 62,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = DW'(num_i >> QW);
      assign low_in  = num_i[QW-1:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // shift in next numerator bit, trial subtract
    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_q[s]  <= {low_in[QW-2:0], 1'b0};
        quo_q[s]  <= {quo_in[QW-2:0], ge};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

// ===== rtl/avoided_crossing_potential_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i                   cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o    position_i
// out       out        out_valid_o / out_stall_i  level_o, grad_*, curv_*, zero_level_o
//
// One item per cycle while in_stall_o is low.
// Depth is set by the exp series (3 stages per term), the exp(-1) chain, the three
// bit-serial dividers and the square root, all one step per stage.
// Reset clears all valid bits and loads both registers with 1.0.
// The pipeline freezes only when the output register and the skid entry are both full.
module avoided_crossing_potential_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [acpe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [15:0]               position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      level_o,
  output logic signed [31:0]               grad_upper_o,
  output logic signed [31:0]               grad_lower_o,
  output logic signed [31:0]               curv_upper_o,
  output logic signed [31:0]               curv_lower_o,
  output logic                             zero_level_o
);

  localparam int unsigned TAY_N = 14;
  localparam int unsigned CHN_N = 32;
  localparam int unsigned SQ_N  = 29;

  typedef struct packed {
    logic [29:0] t;
    logic [5:0]  n;
    logic        xneg;
    logic [30:0] term;
    logic [31:0] pos;
    logic [31:0] neg;
    logic [30:0] work;
    logic [30:0] qe;
  } tay_t;

  typedef struct packed {
    logic [30:0] e;
    logic [5:0]  n;
    logic        xneg;
  } chn_t;

  typedef struct packed {
    logic [30:0] sm;
    logic [27:0] as24;
    logic [30:0] sm2;
    logic        xneg;
  } p1_t;

  typedef struct packed {
    logic [30:0] sm;
    logic [30:0] sm2;
    logic [55:0] as2;
    logic [55:0] d2;
    logic [30:0] c;
    logic [31:0] a2;
    logic        xneg;
  } p2_t;

  typedef struct packed {
    logic [55:0] d2;
    logic [30:0] c;
    logic [31:0] a2;
    logic [30:0] sm;
    logic [30:0] sm2;
    logic        xneg;
    logic        zero;
  } sqs_t;

  typedef struct packed {
    logic [56:0] v2;
    logic [56:0] rem;
    logic [28:0] root;
    sqs_t        side;
  } sqr_t;

  typedef struct packed {
    logic [61:0] num;
    logic [28:0] v24;
    logic [56:0] v2;
    logic [55:0] d2;
    logic [30:0] c;
    logic [30:0] sm;
    logic [30:0] sm2;
    logic        xneg;
    logic        zero;
  } p4_t;

  typedef struct packed {
    logic [28:0] v24;
    logic [56:0] v2;
    logic [55:0] d2;
    logic [30:0] c;
    logic [30:0] sm;
    logic [30:0] sm2;
    logic        xneg;
    logic        zero;
  } wsd_t;

  typedef struct packed {
    logic [61:0] w;
    logic [28:0] v24;
    logic [30:0] c;
    logic [30:0] sm;
    logic [30:0] sm2;
    logic        xneg;
    logic        zero;
  } dsd_t;

  typedef struct packed {
    logic [30:0] cd;
    logic [31:0] t2;
    logic [61:0] w;
    logic [30:0] sm;
    logic        xneg;
    logic        zero;
    logic [28:0] v24;
  } p5_t;

  typedef struct packed {
    logic        fneg;
    logic [31:0] fmag;
    logic [62:0] ghi;
    logic [30:0] glo;
    logic [61:0] w;
    logic        xneg;
    logic        zero;
    logic [28:0] v24;
  } p6_t;

  typedef struct packed {
    logic [63:0] g30;
    logic [63:0] dhi;
    logic [31:0] dlo;
    logic        fneg;
    logic        xneg;
    logic        zero;
    logic [28:0] v24;
  } p7_t;

  typedef struct packed {
    logic [63:0] dd30;
    logic [31:0] gu;
    logic        fneg;
    logic        zero;
    logic [28:0] v24;
  } p8_t;

  typedef struct packed {
    logic [31:0] level;
    logic [31:0] gu;
    logic [31:0] gl;
    logic [31:0] cu;
    logic [31:0] cl;
    logic        zero;
  } res_t;

  // Configuration registers
  logic [15:0] alpha_q;
  logic [15:0] gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= acpe_pkg::ALPHA_GAIN_RESET;
      gap_q   <= acpe_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        acpe_pkg::REG_ALPHA_GAIN: alpha_q <= cfg_data_i;
        acpe_pkg::REG_GAP:        gap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the pipe stops only when the skid entry holds an item
  logic en;
  logic skid_vld_q;
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // Input stage: |x| split into fraction (series argument) and integer part
  tay_t        in_d, in_q;
  logic        in_vld_q;
  logic [15:0] pos_raw;
  logic [15:0] pos_abs;

  assign pos_raw = position_i;
  assign pos_abs = pos_raw[15] ? (16'd0 - pos_raw) : pos_raw;

  always_comb begin
    in_d      = '0;
    in_d.t    = {pos_abs[9:0], 20'd0};
    in_d.n    = pos_abs[15:10];
    in_d.xneg = pos_raw[15];
    in_d.term = acpe_pkg::ONE_Q30;
    in_d.pos  = 32'(acpe_pkg::ONE_Q30);
    in_d.neg  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  // exp(-t) series: per term multiply, reciprocal multiply, correct and accumulate
  tay_t tm_q [TAY_N];
  tay_t tr_q [TAY_N];
  tay_t tc_q [TAY_N];
  logic tm_vld_q [TAY_N];
  logic tr_vld_q [TAY_N];
  logic tc_vld_q [TAY_N];

  for (genvar k = 0; k < TAY_N; k++) begin : g_tay
    localparam int unsigned DIV = k + 1;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);
    tay_t        src;
    logic        src_vld;
    tay_t        m_d;
    tay_t        r_d;
    tay_t        c_d;
    logic [34:0] qk;
    logic [34:0] rem;

    if (k == 0) begin : g_first
      assign src     = in_q;
      assign src_vld = in_vld_q;
    end else begin : g_next
      assign src     = tc_q[k-1];
      assign src_vld = tc_vld_q[k-1];
    end

    always_comb begin
      m_d      = src;
      m_d.work = 31'((61'(src.term) * 61'(src.t)) >> 30);
    end

    always_comb begin
      r_d    = tm_q[k];
      r_d.qe = 31'((64'(tm_q[k].work) * 64'(RECIP)) >> 32);
    end

    // estimate is at most one low
    assign qk  = 35'(tr_q[k].qe) * 35'(DIV);
    assign rem = 35'(tr_q[k].work) - qk;

    always_comb begin
      c_d      = tr_q[k];
      c_d.term = tr_q[k].qe + 31'(rem >= 35'(DIV));
      if (DIV % 2 == 1) begin
        c_d.neg = tr_q[k].neg + 32'(c_d.term);
      end else begin
        c_d.pos = tr_q[k].pos + 32'(c_d.term);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tm_vld_q[k] <= 1'b0;
        tr_vld_q[k] <= 1'b0;
        tc_vld_q[k] <= 1'b0;
      end else if (en) begin
        tm_vld_q[k] <= src_vld;
        tr_vld_q[k] <= tm_vld_q[k];
        tc_vld_q[k] <= tr_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        tm_q[k] <= m_d;
        tr_q[k] <= r_d;
        tc_q[k] <= c_d;
      end
    end
  end

  // Series result
  chn_t ex_d, ex_q;
  logic ex_vld_q;

  always_comb begin
    ex_d.e    = 31'(tc_q[TAY_N-1].pos - tc_q[TAY_N-1].neg);
    ex_d.n    = tc_q[TAY_N-1].n;
    ex_d.xneg = tc_q[TAY_N-1].xneg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
    end else if (en) begin
      ex_vld_q <= tc_vld_q[TAY_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q <= ex_d;
    end
  end

  // Integer part: multiply by exp(-1) once per stage while the stage is below n
  chn_t ch_q [CHN_N];
  logic ch_vld_q [CHN_N];

  for (genvar j = 0; j < CHN_N; j++) begin : g_chn
    chn_t src;
    logic src_vld;
    chn_t ch_d;

    if (j == 0) begin : g_first
      assign src     = ex_q;
      assign src_vld = ex_vld_q;
    end else begin : g_next
      assign src     = ch_q[j-1];
      assign src_vld = ch_vld_q[j-1];
    end

    always_comb begin
      ch_d = src;
      if (6'(j) < src.n) begin
        ch_d.e = 31'((61'(src.e) * 61'(acpe_pkg::EM1_Q30)) >> 30);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ch_vld_q[j] <= 1'b0;
      end else if (en) begin
        ch_vld_q[j] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ch_q[j] <= ch_d;
      end
    end
  end

  // |s| = (1 - e) / (1 + e) in Q30
  logic        s_vld;
  logic [30:0] s_quo;
  logic        s_xneg;

  acpe_div #(
    .NW(61),
    .DW(32),
    .QW(31),
    .SW(1)
  ) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ch_vld_q[CHN_N-1]),
    .num_i   ({acpe_pkg::ONE_Q30 - ch_q[CHN_N-1].e, 30'd0}),
    .den_i   (32'(acpe_pkg::ONE_Q30) + 32'(ch_q[CHN_N-1].e)),
    .side_i  (ch_q[CHN_N-1].xneg),
    .valid_o (s_vld),
    .quo_o   (s_quo),
    .side_o  (s_xneg)
  );

  // alpha*|s| and s^2
  p1_t p1_d, p1_q;
  logic p1_vld_q;

  always_comb begin
    p1_d.sm   = s_quo;
    p1_d.as24 = 28'((47'(alpha_q) * 47'(s_quo)) >> 18);
    p1_d.sm2  = 31'((62'(s_quo) * 62'(s_quo)) >> 30);
    p1_d.xneg = s_xneg;
  end

  // squares of the two legs, 1 - s^2, alpha^2
  p2_t p2_d, p2_q;
  logic p2_vld_q;

  always_comb begin
    p2_d.sm   = p1_q.sm;
    p2_d.sm2  = p1_q.sm2;
    p2_d.as2  = 56'(p1_q.as24) * 56'(p1_q.as24);
    p2_d.d2   = 56'(32'(gap_q) * 32'(gap_q)) << 24;
    p2_d.c    = acpe_pkg::ONE_Q30 - p1_q.sm2;
    p2_d.a2   = 32'(alpha_q) * 32'(alpha_q);
    p2_d.xneg = p1_q.xneg;
  end

  // v^2 and the zero flag; this register feeds the root
  sqr_t p3_d, p3_q;
  logic p3_vld_q;

  always_comb begin
    p3_d.v2        = 57'(p2_q.as2) + 57'(p2_q.d2);
    p3_d.rem       = p3_d.v2;
    p3_d.root      = '0;
    p3_d.side.d2   = p2_q.d2;
    p3_d.side.c    = p2_q.c;
    p3_d.side.a2   = p2_q.a2;
    p3_d.side.sm   = p2_q.sm;
    p3_d.side.sm2  = p2_q.sm2;
    p3_d.side.xneg = p2_q.xneg;
    p3_d.side.zero = (p3_d.v2 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= s_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  // Integer square root, one root bit per stage from the top
  sqr_t sq_q [SQ_N];
  logic sq_vld_q [SQ_N];

  for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
    localparam int unsigned BIT = SQ_N - 1 - s;
    sqr_t        src;
    logic        src_vld;
    sqr_t        sq_d;
    logic [56:0] trial;

    if (s == 0) begin : g_first
      assign src     = p3_q;
      assign src_vld = p3_vld_q;
    end else begin : g_next
      assign src     = sq_q[s-1];
      assign src_vld = sq_vld_q[s-1];
    end

    // (r + 2^b)^2 - r^2, with r holding only bits above b
    assign trial = (57'(src.root) << (BIT + 1)) | (57'(1) << (2 * BIT));

    always_comb begin
      sq_d = src;
      if (src.rem >= trial) begin
        sq_d.rem  = src.rem - trial;
        sq_d.root = src.root | (29'(1) << BIT);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s] <= 1'b0;
      end else if (en) begin
        sq_vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[s] <= sq_d;
      end
    end
  end

  // alpha^2 * (1 - s^2)
  p4_t p4_d, p4_q;
  logic p4_vld_q;

  always_comb begin
    p4_d.num  = 62'(sq_q[SQ_N-1].side.a2) * 62'(sq_q[SQ_N-1].side.c);
    p4_d.v24  = sq_q[SQ_N-1].root;
    p4_d.v2   = sq_q[SQ_N-1].v2;
    p4_d.d2   = sq_q[SQ_N-1].side.d2;
    p4_d.c    = sq_q[SQ_N-1].side.c;
    p4_d.sm   = sq_q[SQ_N-1].side.sm;
    p4_d.sm2  = sq_q[SQ_N-1].side.sm2;
    p4_d.xneg = sq_q[SQ_N-1].side.xneg;
    p4_d.zero = sq_q[SQ_N-1].side.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else if (en) begin
      p4_vld_q <= sq_vld_q[SQ_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q <= p4_d;
    end
  end

  // w = alpha^2 (1 - s^2) / v
  wsd_t        w_side_in;
  wsd_t        w_side;
  logic        w_vld;
  logic [61:0] w_quo;

  always_comb begin
    w_side_in.v24  = p4_q.v24;
    w_side_in.v2   = p4_q.v2;
    w_side_in.d2   = p4_q.d2;
    w_side_in.c    = p4_q.c;
    w_side_in.sm   = p4_q.sm;
    w_side_in.sm2  = p4_q.sm2;
    w_side_in.xneg = p4_q.xneg;
    w_side_in.zero = p4_q.zero;
  end

  acpe_div #(
    .NW(62),
    .DW(29),
    .QW(62),
    .SW($bits(wsd_t))
  ) u_div_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p4_vld_q),
    .num_i   (p4_q.num),
    .den_i   (p4_q.v24),
    .side_i  (w_side_in),
    .valid_o (w_vld),
    .quo_o   (w_quo),
    .side_o  (w_side)
  );

  // delta^2 / v^2 in Q30
  dsd_t        d_side_in;
  dsd_t        d_side;
  logic        d_vld;
  logic [30:0] d_quo;

  always_comb begin
    d_side_in.w    = w_quo;
    d_side_in.v24  = w_side.v24;
    d_side_in.c    = w_side.c;
    d_side_in.sm   = w_side.sm;
    d_side_in.sm2  = w_side.sm2;
    d_side_in.xneg = w_side.xneg;
    d_side_in.zero = w_side.zero;
  end

  acpe_div #(
    .NW(86),
    .DW(57),
    .QW(31),
    .SW($bits(dsd_t))
  ) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (w_vld),
    .num_i   ({w_side.d2, 30'd0}),
    .den_i   (w_side.v2),
    .side_i  (d_side_in),
    .valid_o (d_vld),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  // (1 - s^2) * delta^2/v^2 and 2 s^2
  p5_t p5_d, p5_q;
  logic p5_vld_q;

  always_comb begin
    p5_d.cd   = 31'((62'(d_side.c) * 62'(d_quo)) >> 30);
    p5_d.t2   = {d_side.sm2, 1'b0};
    p5_d.w    = d_side.w;
    p5_d.sm   = d_side.sm;
    p5_d.xneg = d_side.xneg;
    p5_d.zero = d_side.zero;
    p5_d.v24  = d_side.v24;
  end

  // curvature factor with sign; gradient partial products
  p6_t p6_d, p6_q;
  logic p6_vld_q;

  always_comb begin
    p6_d.fneg = (32'(p5_q.cd) < p5_q.t2);
    p6_d.fmag = p6_d.fneg ? (p5_q.t2 - 32'(p5_q.cd)) : (32'(p5_q.cd) - p5_q.t2);
    p6_d.ghi  = 63'(p5_q.w[61:30]) * 63'(p5_q.sm);
    p6_d.glo  = 31'((61'(p5_q.w[29:0]) * 61'(p5_q.sm)) >> 30);
    p6_d.w    = p5_q.w;
    p6_d.xneg = p5_q.xneg;
    p6_d.zero = p5_q.zero;
    p6_d.v24  = p5_q.v24;
  end

  // gradient sum; curvature partial products
  p7_t p7_d, p7_q;
  logic p7_vld_q;

  always_comb begin
    p7_d.g30  = 64'(p6_q.ghi) + 64'(p6_q.glo);
    p7_d.dhi  = 64'(p6_q.w[61:30]) * 64'(p6_q.fmag);
    p7_d.dlo  = 32'((62'(p6_q.w[29:0]) * 62'(p6_q.fmag)) >> 30);
    p7_d.fneg = p6_q.fneg;
    p7_d.xneg = p6_q.xneg;
    p7_d.zero = p6_q.zero;
    p7_d.v24  = p6_q.v24;
  end

  // curvature sum; gradient to Q16.16
  p8_t p8_d, p8_q;
  logic p8_vld_q;

  always_comb begin
    p8_d.dd30 = p7_q.dhi + 64'(p7_q.dlo);
    p8_d.gu   = acpe_pkg::to_q16(p7_q.g30, p7_q.xneg);
    p8_d.fneg = p7_q.fneg;
    p8_d.zero = p7_q.zero;
    p8_d.v24  = p7_q.v24;
  end

  // final result with zero-level override
  res_t        fin_d, fin_q;
  logic        fin_vld_q;
  logic [31:0] cu;

  assign cu = acpe_pkg::to_q16(p8_q.dd30, p8_q.fneg);

  always_comb begin
    fin_d.zero  = p8_q.zero;
    fin_d.level = p8_q.zero ? 32'd0 : 32'(p8_q.v24 >> 8);
    fin_d.gu    = p8_q.zero ? 32'd0 : p8_q.gu;
    fin_d.gl    = 32'd0 - fin_d.gu;
    fin_d.cu    = p8_q.zero ? 32'd0 : cu;
    fin_d.cl    = 32'd0 - fin_d.cu;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      p7_vld_q  <= 1'b0;
      p8_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
    end else if (en) begin
      p5_vld_q  <= d_vld;
      p6_vld_q  <= p5_vld_q;
      p7_vld_q  <= p6_vld_q;
      p8_vld_q  <= p7_vld_q;
      fin_vld_q <= p8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q  <= p5_d;
      p6_q  <= p6_d;
      p7_q  <= p7_d;
      p8_q  <= p8_d;
      fin_q <= fin_d;
    end
  end

  // Output register with one skid entry
  res_t out_d, out_q;
  res_t skid_d, skid_q;
  logic out_vld_d, out_vld_q;
  logic skid_vld_d;
  logic out_fire;
  logic push;

  assign out_fire = out_vld_q && !out_stall_i;
  assign push     = en && fin_vld_q;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (out_fire) begin
      out_vld_d = 1'b0;
    end
    if (skid_vld_q && out_fire) begin
      out_d      = skid_q;
      out_vld_d  = 1'b1;
      skid_vld_d = 1'b0;
    end else if (push) begin
      if (out_vld_q && !out_fire) begin
        skid_d     = fin_q;
        skid_vld_d = 1'b1;
      end else begin
        out_d     = fin_q;
        out_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_vld_q;
  assign level_o      = out_q.level;
  assign grad_upper_o = $signed(out_q.gu);
  assign grad_lower_o = $signed(out_q.gl);
  assign curv_upper_o = $signed(out_q.cu);
  assign curv_lower_o = $signed(out_q.cl);
  assign zero_level_o = out_q.zero;

endmodule

`default_nettype wire
